@@ hdl/fwt_pkg.sv @@
package fwt_pkg;

   localparam int FuncW = 2;
   localparam int FenceW = 64;
   localparam int EventIdW = 8;
   localparam int StatusW = 3;
   localparam int CsrAddrW = 4;
   localparam int CsrDataW = 64;

   localparam int WaiterDepthDefault = 16;
   localparam int EventBitsDefault = 8;

   localparam logic [FuncW-1:0] FUNC_WAIT = 2'd0;
   localparam logic [FuncW-1:0] FUNC_SIGNAL = 2'd1;

   localparam logic CSR_IDX_INITIAL_VALUE = 1'b0;

   typedef enum logic [1:0] {
      OP_WAIT,
      OP_NULL,
      OP_SIGNAL,
      OP_QUERY
   } op_type;

   typedef enum logic [StatusW-1:0] {
      ST_QUEUED = 3'd0,
      ST_FIRED = 3'd1,
      ST_NULL_ID = 3'd2,
      ST_FULL = 3'd3,
      ST_IGNORED = 3'd4,
      ST_NONE = 3'd5,
      ST_QUERY = 3'd6
   } status_type;

   typedef struct packed {
      op_type op;
      logic [FenceW-1:0] operand;
      logic [EventIdW-1:0] event_id;
   } cmd_type;

   typedef struct packed {
      logic load;
      logic [FenceW-1:0] value;
   } cfg_type;

endpackage

@@ hdl/fwt_front.sv @@
module fwt_front
   import fwt_pkg::*;
#(
   parameter int EVENT_BITS = EventBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [FuncW-1:0] req_func,
   input  logic [FenceW-1:0] req_operand_value,
   input  logic [EventIdW-1:0] req_event_id,
   output logic cq_valid,
   output cmd_type cq_cmd,
   input  logic cq_pop
);

   localparam int EvW = (EVENT_BITS < EventIdW) ? EVENT_BITS : EventIdW;

   cmd_type q_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic push;
   logic [EventIdW-1:0] ev_masked;
   cmd_type cmd_new;

   assign req_ready = (cnt_ff != 2'd2);
   assign push = req_valid && req_ready;
   assign cq_valid = (cnt_ff != 2'd0);
   assign cq_cmd = q_ff[rd_ptr_ff];

   assign ev_masked = EventIdW'(req_event_id[EvW-1:0]);

   // classify the incoming word
   always_comb begin
      cmd_new.operand = req_operand_value;
      cmd_new.event_id = ev_masked;
      unique case (req_func)
         FUNC_WAIT: begin
            cmd_new.op = (ev_masked == '0) ? OP_NULL : OP_WAIT;
         end
         FUNC_SIGNAL: begin
            cmd_new.op = OP_SIGNAL;
         end
         default: begin
            cmd_new.op = OP_QUERY;
         end
      endcase
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cq_pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(cq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

@@ hdl/fwt_back.sv @@
module fwt_back
   import fwt_pkg::*;
#(
   parameter int WAITER_DEPTH = WaiterDepthDefault,
   parameter int EVENT_BITS = EventBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  cfg_type cfg,
   input  logic cq_valid,
   input  cmd_type cq_cmd,
   output logic cq_pop,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [StatusW-1:0] rsp_status,
   output logic [EventIdW-1:0] rsp_fired_event,
   output logic [FenceW-1:0] rsp_fence_value_out,
   output logic rsp_last
);

   localparam int IdxW = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
   localparam int CntW = $clog2(WAITER_DEPTH + 1);
   localparam int EvW = (EVENT_BITS < EventIdW) ? EVENT_BITS : EventIdW;
   localparam logic [CntW-1:0] DepthCnt = CntW'(WAITER_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_CHECK,
      S_FINISH
   } state_type;

   logic [FenceW-1:0] thr_mem [WAITER_DEPTH];
   logic [EvW-1:0] evt_mem [WAITER_DEPTH];

   state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   logic [FenceW-1:0] fence_ff, fence_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] scan_ff, scan_in;
   logic [CntW-1:0] keep_ff, keep_in;
   logic pend_valid_ff, pend_valid_in;
   logic [EvW-1:0] pend_event_ff, pend_event_in;
   logic [FenceW-1:0] rd_thr_ff;
   logic [EvW-1:0] rd_evt_ff;

   logic rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff, rsp_status_in;
   logic [EventIdW-1:0] rsp_event_ff, rsp_event_in;
   logic [FenceW-1:0] rsp_fence_ff, rsp_fence_in;
   logic rsp_last_ff, rsp_last_in;

   logic out_free;
   logic mem_wr_en;
   logic [IdxW-1:0] mem_wr_addr;
   logic [FenceW-1:0] mem_wr_thr;
   logic [EvW-1:0] mem_wr_evt;
   logic mem_rd_en;
   logic [IdxW-1:0] mem_rd_addr;
   logic [CntW-1:0] scan_nx;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign scan_nx = scan_ff + CntW'(1);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_fired_event = rsp_event_ff;
   assign rsp_fence_value_out = rsp_fence_ff;
   assign rsp_last = rsp_last_ff;

   always_comb begin
      state_in = state_ff;
      cmd_in = cmd_ff;
      fence_in = fence_ff;
      count_in = count_ff;
      scan_in = scan_ff;
      keep_in = keep_ff;
      pend_valid_in = pend_valid_ff;
      pend_event_in = pend_event_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_event_in = rsp_event_ff;
      rsp_last_in = rsp_last_ff;
      cq_pop = 1'b0;
      mem_wr_en = 1'b0;
      mem_wr_addr = count_ff[IdxW-1:0];
      mem_wr_thr = cmd_ff.operand;
      mem_wr_evt = cmd_ff.event_id[EvW-1:0];
      mem_rd_en = 1'b0;
      mem_rd_addr = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (cq_valid) begin
               cmd_in = cq_cmd;
               cq_pop = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_event_in = '0;
               rsp_last_in = 1'b1;
               state_in = S_IDLE;
               unique case (cmd_ff.op)
                  OP_NULL: begin
                     rsp_status_in = ST_NULL_ID;
                  end
                  OP_WAIT: begin
                     if (fence_ff >= cmd_ff.operand) begin
                        rsp_status_in = ST_FIRED;
                        rsp_event_in = cmd_ff.event_id;
                     end else if (count_ff == DepthCnt) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        rsp_status_in = ST_QUEUED;
                        mem_wr_en = 1'b1;
                        count_in = count_ff + CntW'(1);
                     end
                  end
                  OP_SIGNAL: begin
                     if (cmd_ff.operand <= fence_ff) begin
                        rsp_status_in = ST_IGNORED;
                     end else begin
                        fence_in = cmd_ff.operand;
                        rsp_status_in = ST_NONE;
                        if (count_ff != '0) begin
                           rsp_valid_in = rsp_valid_ff && !rsp_ready;
                           rsp_status_in = rsp_status_ff;
                           rsp_event_in = rsp_event_ff;
                           rsp_last_in = rsp_last_ff;
                           scan_in = '0;
                           keep_in = '0;
                           pend_valid_in = 1'b0;
                           mem_rd_en = 1'b1;
                           state_in = S_CHECK;
                        end
                     end
                  end
                  default: begin
                     rsp_status_in = ST_QUERY;
                  end
               endcase
            end
         end
         S_CHECK: begin
            if (rd_thr_ff <= fence_ff) begin
               if (!pend_valid_ff || out_free) begin
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_status_in = ST_FIRED;
                     rsp_event_in = EventIdW'(pend_event_ff);
                     rsp_last_in = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_event_in = rd_evt_ff;
                  scan_in = scan_nx;
               end
            end else begin
               // compact: move the survivor down to the keep slot
               mem_wr_en = 1'b1;
               mem_wr_addr = keep_ff[IdxW-1:0];
               mem_wr_thr = rd_thr_ff;
               mem_wr_evt = rd_evt_ff;
               keep_in = keep_ff + CntW'(1);
               scan_in = scan_nx;
            end
            if (scan_in != scan_ff) begin
               if (scan_nx == count_ff) begin
                  state_in = S_FINISH;
               end else begin
                  mem_rd_en = 1'b1;
                  mem_rd_addr = scan_nx[IdxW-1:0];
               end
            end
         end
         default: begin
            if (out_free) begin
               count_in = keep_ff;
               rsp_valid_in = 1'b1;
               rsp_last_in = 1'b1;
               if (pend_valid_ff) begin
                  rsp_status_in = ST_FIRED;
                  rsp_event_in = EventIdW'(pend_event_ff);
               end else begin
                  rsp_status_in = ST_NONE;
                  rsp_event_in = '0;
               end
               pend_valid_in = 1'b0;
               state_in = S_IDLE;
            end
         end
      endcase

      rsp_fence_in = (rsp_valid_in && !(rsp_valid_ff && !rsp_ready)) ? fence_in : rsp_fence_ff;

      if (cfg.load) begin
         fence_in = cfg.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         fence_ff <= '0;
         count_ff <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fence_ff <= fence_in;
         count_ff <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff <= cmd_in;
      scan_ff <= scan_in;
      keep_ff <= keep_in;
      pend_event_ff <= pend_event_in;
      rsp_status_ff <= rsp_status_in;
      rsp_event_ff <= rsp_event_in;
      rsp_fence_ff <= rsp_fence_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         thr_mem[mem_wr_addr] <= mem_wr_thr;
         evt_mem[mem_wr_addr] <= mem_wr_evt;
      end
      if (mem_rd_en) begin
         rd_thr_ff <= thr_mem[mem_rd_addr];
         rd_evt_ff <= evt_mem[mem_rd_addr];
      end
   end

endmodule

@@ hdl/fence_waiter_table.sv @@
// a wait, query or rejected word passes the command queue, the command register and the result register
// signal on a table of n > 0 waiters: the scan reads every waiter before the last result is valid
// the table unit takes one word at a time and the scan sets the signal cost;
// a 2-entry command queue lets new words in while the table unit is busy
// reset clears control, empties the table and sets the fence value to zero
module fence_waiter_table
   import fwt_pkg::*;
#(
   parameter int WAITER_DEPTH = WaiterDepthDefault,
   parameter int EVENT_BITS = EventBitsDefault
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [FuncW-1:0] req_func,
   input  logic [FenceW-1:0] req_operand_value,
   input  logic [EventIdW-1:0] req_event_id,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [StatusW-1:0] rsp_status,
   output logic [EventIdW-1:0] rsp_fired_event,
   output logic [FenceW-1:0] rsp_fence_value_out,
   output logic rsp_last,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [CsrAddrW-1:0] csr_paddr,
   input  logic [CsrDataW-1:0] csr_pwdata,
   output logic [CsrDataW-1:0] csr_prdata,
   output logic csr_pready
);

   logic [FenceW-1:0] initial_value_ff, initial_value_in;
   logic csr_hit;
   cfg_type cfg;
   logic cq_valid;
   cmd_type cq_cmd;
   logic cq_pop;

   // registers sit on 8-byte boundaries, the top address bit is the index
   assign csr_hit = (csr_paddr[CsrAddrW-1] == CSR_IDX_INITIAL_VALUE);
   assign csr_pready = 1'b1;
   assign cfg.load = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign cfg.value = FenceW'(csr_pwdata);
   assign initial_value_in = cfg.load ? cfg.value : initial_value_ff;
   assign csr_prdata = csr_hit ? CsrDataW'(initial_value_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         initial_value_ff <= '0;
      end else begin
         initial_value_ff <= initial_value_in;
      end
   end

   fwt_front #(
      .EVENT_BITS(EVENT_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_func(req_func),
      .req_operand_value(req_operand_value),
      .req_event_id(req_event_id),
      .cq_valid(cq_valid),
      .cq_cmd(cq_cmd),
      .cq_pop(cq_pop)
   );

   fwt_back #(
      .WAITER_DEPTH(WAITER_DEPTH),
      .EVENT_BITS(EVENT_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .cq_valid(cq_valid),
      .cq_cmd(cq_cmd),
      .cq_pop(cq_pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_fired_event(rsp_fired_event),
      .rsp_fence_value_out(rsp_fence_value_out),
      .rsp_last(rsp_last)
   );

endmodule

@@ hdl/fwt_checker.sv @@
module fwt_checker
   import fwt_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [StatusW-1:0] rsp_status,
   input logic [EventIdW-1:0] rsp_fired_event,
   input logic [FenceW-1:0] rsp_fence_value_out,
   input logic rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_fence_value_out) && $stable(rsp_fired_event) && $stable(rsp_last))
      else $error("result word changed while stalled");

   a_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FIRED |-> rsp_fired_event == '0)
      else $error("event id on a non-fired result");

   a_fired_id: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_FIRED |-> rsp_fired_event != '0)
      else $error("fired result with null event id");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_FIRED |-> rsp_last)
      else $error("single-result status without last");

endmodule

bind fence_waiter_table fwt_checker u_fwt_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_status(rsp_status),
   .rsp_fired_event(rsp_fired_event),
   .rsp_fence_value_out(rsp_fence_value_out),
   .rsp_last(rsp_last)
);
